/* sv/hsb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsb_pkg
// Shared types and constants of the HMAC-SHA1 base64 block.
// ----------------------------------------------------------------------------
package hsb_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int KEY_BITS    = BLOCK_BYTES * 8;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int CHAR_COUNT  = 28;

    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5c;
    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [7:0] B64_FILL  = 8'h3d;

    localparam logic [159:0] SHA_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    // one message byte plus its classification
    typedef struct packed {
        logic [7:0] data;
        logic       final_byte;
        logic       first_byte;
    } t_item;

    // one base64 character of the answer
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            r = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            r = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            r = 8'h2b;
        end else begin
            r = 8'h2f;
        end
        return r;
    endfunction

endpackage

/* sv/hsb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsb_front
// Accept message bytes, tag the first byte of each message, queue them.
// ----------------------------------------------------------------------------
module hsb_front import hsb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_data,
    input  logic       i_final,
    output logic       o_full,
    output logic       o_valid,
    output t_item      o_item,
    input  logic       i_pop
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wr;
    logic [Q_AW-1:0]    r_rd;
    logic [Q_AW:0]      r_cnt;
    logic               r_in_msg;
    logic               w_push;
    logic               w_pop;
    t_item              w_item;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        w_item.data       = i_data;
        w_item.final_byte = i_final;
        w_item.first_byte = !r_in_msg;
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        o_item <= r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr     <= '0;
            r_rd     <= '0;
            r_cnt    <= '0;
            r_in_msg <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr     <= r_wr + 1'b1;
                r_in_msg <= !i_final;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW+1)'(w_push) - (Q_AW+1)'(w_pop);
        end
    end

endmodule

/* sv/hsb_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsb_outq
// Result queue holding base64 characters until the receiver pops them.
// ----------------------------------------------------------------------------
module hsb_outq import hsb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_char i_char,
    output logic o_full,
    output logic o_empty,
    output t_char o_char,
    input  logic i_pop
);

    t_char           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_char  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW+1)'(w_push) - (Q_AW+1)'(w_pop);
        end
    end

endmodule

/* sv/hsb_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsb_engine
// Sequencer with one SHA-1 round unit: pads, compresses, encodes base64.
// ----------------------------------------------------------------------------
module hsb_engine import hsb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic                i_valid,
    input  t_item               i_item,
    output logic                o_pop,
    input  logic                i_out_full,
    output logic                o_push,
    output t_char               o_char
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_WAIT, ST_IPAD, ST_ABSORB, ST_FIN, ST_ZERO, ST_LEN,
        ST_ROUND, ST_ADD, ST_DONE, ST_DIG, ST_B64
    } t_state;

    t_state          r_state, n_state;
    t_state          r_ret, n_ret;
    logic [6:0]      r_round, n_round;
    logic [31:0]     r_a, r_b, r_c, r_d, r_e;
    logic [31:0]     n_a, n_b, n_c, n_d, n_e;
    logic [159:0]    r_chain, n_chain;
    logic [KEY_BITS-1:0] r_blk, n_blk;
    logic [60:0]     r_count, n_count;
    logic [5:0]      r_pos, n_pos;
    logic [63:0]     r_len, n_len;
    logic [7:0]      r_byte, n_byte;
    logic            r_final, n_final;
    logic            r_outer, n_outer;
    logic [159:0]    r_inner, n_inner;
    logic [167:0]    r_dig, n_dig;
    logic [4:0]      r_idx, n_idx;
    logic            w_start;

    logic [31:0] w_f, w_k, w_t, w_new;

    // round function
    always_comb begin
        if (r_round < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = 32'h5A827999;
        end else if (r_round < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = 32'h6ED9EBA1;
        end else if (r_round < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = 32'h8F1BBCDC;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = 32'hCA62C1D6;
        end
        w_t = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_blk[511:480];
        w_new = r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ r_blk[511:480];
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_round = r_round;
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e;
        n_chain = r_chain;
        n_blk   = r_blk;
        n_count = r_count;
        n_pos   = r_pos;
        n_len   = r_len;
        n_byte  = r_byte;
        n_final = r_final;
        n_outer = r_outer;
        n_inner = r_inner;
        n_dig   = r_dig;
        n_idx   = r_idx;
        w_start = 1'b0;
        o_pop   = 1'b0;
        o_push  = 1'b0;
        o_char.ch   = b64_char(r_dig[167:162]);
        o_char.last = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                // queue read data lands this cycle
                n_byte  = i_item.data;
                n_final = i_item.final_byte;
                n_state = i_item.first_byte ? ST_IPAD : ST_ABSORB;
            end
            ST_IPAD: begin
                n_blk   = i_key ^ {BLOCK_BYTES{IPAD_BYTE}};
                n_chain = SHA_IV;
                n_count = 61'(BLOCK_BYTES);
                n_pos   = '0;
                w_start = 1'b1;
                n_ret   = ST_ABSORB;
            end
            ST_ABSORB: begin
                n_blk   = {r_blk[KEY_BITS-9:0], r_byte};
                n_count = r_count + 1'b1;
                n_pos   = r_pos + 1'b1;
                n_state = r_final ? ST_FIN : ST_IDLE;
                if (r_pos == 6'd63) begin
                    w_start = 1'b1;
                    n_ret   = r_final ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: begin
                n_len   = {r_count, 3'b000};
                n_blk   = {r_blk[KEY_BITS-9:0], PAD_MARK};
                n_pos   = r_pos + 1'b1;
                n_state = ST_ZERO;
                if (r_pos == 6'd63) begin
                    w_start = 1'b1;
                    n_ret   = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (r_pos == 6'd56) begin
                    n_state = ST_LEN;
                end else begin
                    n_blk = {r_blk[KEY_BITS-9:0], 8'h00};
                    n_pos = r_pos + 1'b1;
                    if (r_pos == 6'd63) begin
                        w_start = 1'b1;
                        n_ret   = ST_ZERO;
                    end
                end
            end
            ST_LEN: begin
                n_blk = {r_blk[KEY_BITS-9:0], r_len[63:56]};
                n_len = {r_len[55:0], 8'h00};
                n_pos = r_pos + 1'b1;
                if (r_pos == 6'd63) begin
                    w_start = 1'b1;
                    n_ret   = ST_DONE;
                end
            end
            ST_ROUND: begin
                n_a = w_t;
                n_b = r_a;
                n_c = {r_b[1:0], r_b[31:2]};
                n_d = r_c;
                n_e = r_d;
                n_blk   = {r_blk[KEY_BITS-33:0], w_new[30:0], w_new[31]};
                n_round = r_round + 1'b1;
                if (r_round == 7'd79) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_chain = {r_chain[159:128] + r_a, r_chain[127:96] + r_b,
                           r_chain[95:64] + r_c, r_chain[63:32] + r_d,
                           r_chain[31:0] + r_e};
                n_state = r_ret;
            end
            ST_DONE: begin
                n_idx = '0;
                if (!r_outer) begin
                    n_inner = r_chain;
                    n_blk   = i_key ^ {BLOCK_BYTES{OPAD_BYTE}};
                    n_chain = SHA_IV;
                    n_count = 61'(BLOCK_BYTES);
                    n_pos   = '0;
                    n_outer = 1'b1;
                    w_start = 1'b1;
                    n_ret   = ST_DIG;
                end else begin
                    n_dig   = {r_chain, 8'h00};
                    n_state = ST_B64;
                end
            end
            ST_DIG: begin
                n_blk   = {r_blk[KEY_BITS-9:0], r_inner[159:152]};
                n_inner = {r_inner[151:0], 8'h00};
                n_count = r_count + 1'b1;
                n_pos   = r_pos + 1'b1;
                n_idx   = r_idx + 1'b1;
                if (r_idx == 5'd19) begin
                    n_state = ST_FIN;
                end
            end
            ST_B64: begin
                if (!i_out_full) begin
                    o_push = 1'b1;
                    if (r_idx == 5'(CHAR_COUNT - 1)) begin
                        o_char.ch   = B64_FILL;
                        o_char.last = 1'b1;
                        n_outer     = 1'b0;
                        n_state     = ST_IDLE;
                    end
                    n_dig = {r_dig[161:0], 6'b000000};
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // enter the round loop from the chain value about to be stored
        if (w_start) begin
            n_state = ST_ROUND;
            n_round = '0;
            n_a = n_chain[159:128];
            n_b = n_chain[127:96];
            n_c = n_chain[95:64];
            n_d = n_chain[63:32];
            n_e = n_chain[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_round <= '0;
            r_outer <= 1'b0;
            r_idx   <= '0;
            r_chain <= SHA_IV;
            r_count <= 61'(BLOCK_BYTES);
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_round <= n_round;
            r_outer <= n_outer;
            r_idx   <= n_idx;
            r_chain <= n_chain;
            r_count <= n_count;
            r_pos   <= n_pos;
        end
        r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d; r_e <= n_e;
        r_blk   <= n_blk;
        r_len   <= n_len;
        r_byte  <= n_byte;
        r_final <= n_final;
        r_inner <= n_inner;
        r_dig   <= n_dig;
    end

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_round < 7'd80))
        else $error("round counter out of range");

    a_push_only_b64: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_state == ST_B64) && !i_out_full)
        else $error("character pushed outside encoding");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_WAIT))
        else $error("queue pop outside idle");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_char.last) |=> (r_state == ST_IDLE) && !r_outer)
        else $error("last character did not end the message");

endmodule

/* sv/hmac_sha1_base64_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmac_sha1_base64_top
// HMAC-SHA1 over a byte stream, answered as 28 base64 characters.
// ----------------------------------------------------------------------------
// Usage:
//   Load the 64-byte key into eight 64-bit registers through i_cfg_we /
//   i_cfg_index / i_cfg_data (first key byte in bits 63..56 of register 0),
//   only while the block is idle. Push message bytes with push while full
//   is low; raise i_is_final on the last byte of a message.
//   Each final byte causes 28 requests on the result side: pop while empty
//   is low takes the oldest character; o_last_char marks the '=' at the end.
// Operation:
//   The sequencer takes one byte at a time, and every 64th byte adds
//   one compression in the single round unit (80 rounds plus chain add).
//   The first byte of a message adds the inner pad compression. A final
//   byte then takes three or four compressions plus padding and digest
//   shifts before the first character, then one character a cycle while
//   the result queue has room.
// Reset (synchronous, i_rst_n low) empties both queues, clears the key
//   and returns the sequencer to idle. When the receiver stalls, the result
//   queue fills and the sequencer holds; the input queue then fills and
//   full rises.
// ----------------------------------------------------------------------------
module hmac_sha1_base64_top import hsb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_message_byte,
    input  logic        i_is_final,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_base64_char,
    output logic        o_last_char
);

    logic [63:0]         r_key [8];
    logic [KEY_BITS-1:0] w_key;
    logic                w_q_valid;
    t_item               w_q_item;
    logic                w_q_pop;
    logic                w_out_full;
    logic                w_out_push;
    t_char               w_char;
    t_char               w_head;

    // key registers, written whenever the enable is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    // flatten so that key byte 0 sits at the top of the block
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_key[KEY_BITS-1-64*i -: 64] = r_key[i];
        end
    end

    // front: accept and tag bytes
    hsb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_message_byte),
        .i_final (i_is_final),
        .o_full  (full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    // back: hashing and encoding
    hsb_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      (w_key),
        .i_valid    (w_q_valid),
        .i_item     (w_q_item),
        .o_pop      (w_q_pop),
        .i_out_full (w_out_full),
        .o_push     (w_out_push),
        .o_char     (w_char)
    );

    // result queue toward the receiver
    hsb_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_char  (w_char),
        .o_full  (w_out_full),
        .o_empty (empty),
        .o_char  (w_head),
        .i_pop   (pop)
    );

    assign o_base64_char = w_head.ch;
    assign o_last_char   = w_head.last;

endmodule

/* verif/hmac_sha1_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmac_sha1_checker
// Watches the key port and both request channels of the HMAC-SHA1 base64
// block, predicts the 28 characters that each final byte causes, and
// compares every popped character with the oldest prediction.
// ----------------------------------------------------------------------------
module hmac_sha1_checker import hsb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_message_byte,
    input  logic        i_is_final,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [7:0]  i_base64_char,
    input  logic        i_last_char,
    output int          o_fail_count,
    output int          o_pending
);

    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic [63:0] key_mirror [8];
    logic [31:0] chain [5];
    logic [31:0] inner [5];
    logic [7:0]  blk [BLOCK_BYTES];
    logic [60:0] byte_count;
    logic        in_message;
    t_char       char_q [$];

    assign o_pending = char_q.size();

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // one SHA-1 compression of blk into chain
    task automatic compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        end
        for (int i = 16; i < 80; i++) begin
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    task automatic start_pass(input logic [7:0] pad);
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            blk[i] = key_mirror[i / 8][63 - 8 * (i % 8) -: 8] ^ pad;
        end
        for (int i = 0; i < 5; i++) begin
            chain[i] = SHA_IV[159 - 32 * i -: 32];
        end
        compress_block();
        byte_count = 61'(BLOCK_BYTES);
    endtask

    task automatic take_byte(input logic [7:0] v);
        int pos;
        pos = int'(byte_count[5:0]);
        blk[pos] = v;
        byte_count = byte_count + 61'd1;
        if (pos == BLOCK_BYTES - 1) begin
            compress_block();
        end
    endtask

    task automatic close_pass();
        int pos;
        logic [63:0] bit_len;
        pos = int'(byte_count[5:0]);
        bit_len = {byte_count, 3'b000};
        blk[pos] = PAD_MARK;
        pos++;
        if (pos > BLOCK_BYTES - 8) begin
            while (pos < BLOCK_BYTES) begin
                blk[pos] = 8'h00; pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < BLOCK_BYTES - 8) begin
            blk[pos] = 8'h00; pos++;
        end
        for (int i = 0; i < 8; i++) begin
            blk[BLOCK_BYTES - 8 + i] = bit_len[63 - 8 * i -: 8];
        end
        compress_block();
    endtask

    // advance the model by one accepted byte; queue the answer on a final one
    task automatic predict_hmac(input logic [7:0] v, input logic fin);
        logic [7:0]  dig [20];
        logic [23:0] grp;
        t_char       c;
        if (!in_message) begin
            start_pass(IPAD_BYTE);
            in_message = 1'b1;
        end
        take_byte(v);
        if (fin) begin
            close_pass();
            inner = chain;
            start_pass(OPAD_BYTE);
            for (int i = 0; i < 20; i++) begin
                take_byte(inner[i / 4][31 - 8 * (i % 4) -: 8]);
            end
            close_pass();
            for (int i = 0; i < 20; i++) begin
                dig[i] = chain[i / 4][31 - 8 * (i % 4) -: 8];
            end
            for (int g = 0; g < 7; g++) begin
                grp = {dig[3*g], dig[3*g+1], (g < 6) ? dig[3*g+2] : 8'h00};
                for (int i = 0; i < 4; i++) begin
                    if (g == 6 && i == 3) begin
                        c.ch = B64_FILL;
                    end else begin
                        c.ch = ALPHABET[grp[23 - 6 * i -: 6]];
                    end
                    c.last = (g == 6 && i == 3);
                    char_q.push_back(c);
                end
            end
            in_message = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
    end

    always @(posedge i_clk) begin
        t_char want;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) key_mirror[i] = '0;
            in_message = 1'b0;
            byte_count = 61'(BLOCK_BYTES);
            char_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (char_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected char %h", i_base64_char));
                end else begin
                    want = char_q.pop_front();
                    if (i_base64_char !== want.ch) begin
                        report_mismatch($sformatf("char %h, want %h",
                                                  i_base64_char, want.ch));
                    end
                    if (i_last_char !== want.last) begin
                        report_mismatch($sformatf("last flag %b, want %b",
                                                  i_last_char, want.last));
                    end
                end
            end
            if (i_push && !i_full) begin
                predict_hmac(i_message_byte, i_is_final);
            end
            if (i_cfg_we) begin
                key_mirror[i_cfg_index] = i_cfg_data;
            end
        end
    end

endmodule

/* verif/tb_hmac_sha1_base64_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hmac_sha1_base64_top
// Drives key settings and message bytes into the HMAC-SHA1 base64 block
// under random idling on both sides; a checker beside the block predicts
// and compares every character.
// ----------------------------------------------------------------------------
module tb_hmac_sha1_base64_top;
    import hsb_pkg::*;

    localparam int KEY_WORDS   = 8;
    localparam int ITEM_TARGET = 260;
    localparam int IDLE_PCT    = 21;
    localparam int SETTLE      = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        push;
    logic        full;
    logic [7:0]  i_message_byte;
    logic        i_is_final;
    logic        empty;
    logic        pop;
    logic [7:0]  o_base64_char;
    logic        o_last_char;
    int          fail_count;
    int          pending;
    int          sent;
    logic        calm;

    hmac_sha1_base64_top dut (.*);

    hmac_sha1_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_push(push), .i_full(full), .i_message_byte, .i_is_final,
        .i_empty(empty), .i_pop(pop), .i_base64_char(o_base64_char),
        .i_last_char(o_last_char), .o_fail_count(fail_count), .o_pending(pending)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // Receiver: stall at random, never while calm.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Hold one request on the input until the block takes it. Gaps go in
    // before raising push so that valid never drops within one step.
    task automatic send_byte(input logic [7:0] v, input logic fin);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_message_byte <= v;
        i_is_final     <= fin;
        do @(posedge i_clk); while (full);
        sent++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom), i == len - 1);
        end
        push <= 1'b0;
    endtask

    // Drain every expected character, then let the block settle idle.
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_key(input logic [63:0] words [KEY_WORDS]);
        for (int i = 0; i < KEY_WORDS; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data  <= words[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Message lengths: mostly short, sometimes on a padding boundary.
    function automatic int pick_length();
        int edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        if ($urandom_range(99) < 12) begin
            return edges[$urandom_range(7)];
        end
        return $urandom_range(1, 20);
    endfunction

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #(12 * 3_000_000);
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [63:0] words [KEY_WORDS];
        int          phase;
        int          len;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        push           = 1'b0;
        i_message_byte = '0;
        i_is_final     = 1'b0;
        calm           = 1'b0;
        sent           = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero key from reset, one-byte messages at the extremes and one four-byte message.
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hfe, 1'b1);
        drain();

        // All-ones key.
        foreach (words[i]) words[i] = '1;
        load_key(words);
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h55, 1'b1);
        drain();

        // Random phases, each loading a key of one of four shapes in turn.
        phase = 0;
        while (sent < ITEM_TARGET) begin
            case (phase % 5)
                0: foreach (words[i]) words[i] = {$urandom, $urandom};
                1: foreach (words[i]) words[i] = (i < 2) ? {$urandom, $urandom} : '0;
                2: foreach (words[i]) words[i] = (i % 2) ? '1 : '0;
                3: foreach (words[i]) words[i] = '0;
                default: foreach (words[i]) words[i] = {$urandom, $urandom};
            endcase
            load_key(words);
            calm = (phase == 3);
            for (int m = 0; m < 6 && sent < ITEM_TARGET; m++) begin
                len = pick_length();
                // keep the total close to the target
                if (len > ITEM_TARGET - sent) begin
                    len = ITEM_TARGET - sent;
                end
                send_message(len);
                // once, hold off until every answer is in
                if (phase == 1 && m == 2) begin
                    drain();
                end
            end
            calm = 1'b0;
            drain();
            phase++;
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
